FILE: hw/rtl/slnr_pkg.sv
// shared types, widths and codes of the sparse linear node router
// no dependencies; all rtl files of the block but slnr_wmem import this package
package slnr_pkg;

    localparam int FEATURE_SLOTS = 65536;
    localparam int ADDR_W        = $clog2(FEATURE_SLOTS);

    localparam int KIND_W     = 2;
    localparam int IDX_W      = 17;
    localparam int VAL_W      = 32;
    localparam int INST_W     = 20;
    localparam int SCORE_W    = 64;
    localparam int FC_W       = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // epoch tag stored next to each weight; tag 0 marks an entry as absent
    localparam int EPOCH_W = 16;
    localparam int MEM_W   = VAL_W + EPOCH_W;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CREDIT_W   = $clog2(OUTQ_DEPTH + 1);

    localparam logic [FC_W-1:0]         FC_RESET   = FC_W'(65536);
    localparam logic signed [VAL_W-1:0] BIAS_RESET = VAL_W'(65536);

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_BEGIN   = 2'd0,
        KIND_WEIGHT  = 2'd1,
        KIND_FEATURE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEATURE_COUNT = 1'b0,
        CFG_BIAS_INPUT    = 1'b1
    } t_cfg_idx;

    // what an accepted item still has to do past the weight memory
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_BEGIN   = 2'd1,
        OP_BIAS    = 2'd2,
        OP_FEATURE = 2'd3
    } t_op;

    typedef struct packed {
        logic                      vld;
        t_op                       op;
        logic                      in_range;
        logic                      last;
        logic [INST_W-1:0]         inst;
        logic signed [VAL_W-1:0]   value;
        logic [EPOCH_W-1:0]        epoch;
    } t_issue;

    typedef struct packed {
        logic [INST_W-1:0]         inst;
        logic                      goes_right;
        logic signed [SCORE_W-1:0] score;
    } t_result;

endpackage

FILE: hw/rtl/sparse_linear_node_router_top.sv
// throughput one item per cycle while o_stall is low
// weight lookup is one read of the tagged weight ram per feature, one mac per cycle
// up to 8 results queue at the output; input stalls while 8 are owed downstream
// reset (synchronous, active low) starts a clearing pass over all FEATURE_SLOTS entries,
// repeated after every 65535th begin-node transfer; input is stalled during a pass
module sparse_linear_node_router_top import slnr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [VAL_W-1:0]   i_value,
    input  logic [INST_W-1:0]         i_instance_id,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [INST_W-1:0]         o_routed_instance,
    output logic                      o_goes_right,
    output logic signed [SCORE_W-1:0] o_score,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    logic [EPOCH_W-1:0]      r_epoch, n_epoch;
    logic [CREDIT_W-1:0]     r_credit, n_credit;
    logic [FC_W-1:0]         r_feature_count;
    logic signed [VAL_W-1:0] r_bias_input;

    logic              accept;
    logic              pop;
    logic              in_range;
    logic [ADDR_W-1:0] idx_addr;
    logic              wr_weight;
    logic              rd_feature;
    logic              begin_item;
    logic              last_feature;
    t_issue            issue;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [MEM_W-1:0]  mem_rdata;

    logic    res_vld;
    t_result res;
    t_result head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= FC_RESET;
            r_bias_input    <= BIAS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FEATURE_COUNT: begin
                    r_feature_count <= i_cfg_data[FC_W-1:0];
                end
                CFG_BIAS_INPUT: begin
                    r_bias_input <= $signed(i_cfg_data[VAL_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stall = (r_state != ST_RUN) || (r_credit == CREDIT_W'(OUTQ_DEPTH));
    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    assign in_range = (i_index < r_feature_count) &&
                      (32'(i_index) < 32'(FEATURE_SLOTS));
    assign idx_addr = ADDR_W'(i_index);

    always_comb begin
        wr_weight      = 1'b0;
        rd_feature     = 1'b0;
        begin_item     = 1'b0;
        last_feature   = 1'b0;
        issue.vld      = accept;
        issue.op       = OP_NONE;
        issue.in_range = in_range;
        issue.last     = i_last;
        issue.inst     = i_instance_id;
        issue.value    = i_value;
        issue.epoch    = r_epoch;
        case (t_kind'(i_kind))
            KIND_BEGIN: begin
                issue.op   = OP_BEGIN;
                begin_item = accept;
            end
            KIND_WEIGHT: begin
                if (i_index == r_feature_count) begin
                    issue.op = OP_BIAS;
                end else if (in_range) begin
                    wr_weight = accept;
                end
            end
            KIND_FEATURE: begin
                issue.op     = OP_FEATURE;
                rd_feature   = accept;
                last_feature = accept && i_last;
            end
            default: begin
            end
        endcase
    end

    // a begin-node bumps the epoch, which drops every stored weight at once
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_epoch    = r_epoch;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(FEATURE_SLOTS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (begin_item) begin
                    if (r_epoch == EPOCH_LAST) begin
                        // tags would wrap: wipe all tags before reuse
                        n_epoch    = EPOCH_FIRST;
                        n_clr_addr = '0;
                        n_state    = ST_CLEAR;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign n_credit = r_credit + CREDIT_W'(last_feature) - CREDIT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
            r_credit   <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_epoch    <= n_epoch;
            r_credit   <= n_credit;
        end
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = wr_weight;
            mem_waddr = idx_addr;
            mem_wdata = {r_epoch, i_value};
        end
    end

    slnr_wmem #(
        .DATA_W (MEM_W),
        .ADDR_W (ADDR_W),
        .DEPTH  (FEATURE_SLOTS)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (rd_feature),
        .i_raddr (idx_addr),
        .o_rdata (mem_rdata)
    );

    slnr_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (issue),
        .i_rdata      (mem_rdata),
        .i_bias_input (r_bias_input),
        .o_res_vld    (res_vld),
        .o_res        (res)
    );

    slnr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (res),
        .i_pop   (pop),
        .o_vld   (o_valid),
        .o_data  (head)
    );

    assign o_routed_instance = head.inst;
    assign o_goes_right      = head.goes_right;
    assign o_score           = head.score;

endmodule

FILE: hw/rtl/slnr_wmem.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; holds the tagged weight store of the router
module slnr_wmem #(
    parameter int DATA_W = 48,
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/slnr_mac.sv
// multiply-accumulate pipeline: tag check, product, saturating sum, routing test
// depends on slnr_pkg; fed by the weight ram read data and the issue struct
module slnr_mac import slnr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_issue                  i_issue,
    input  logic [MEM_W-1:0]        i_rdata,
    input  logic signed [VAL_W-1:0] i_bias_input,
    output logic                    o_res_vld,
    output t_result                 o_res
);

    // stage 1: lines up with the ram read data
    t_issue r_s1;

    logic signed [VAL_W-1:0]   s1_weight;
    logic [EPOCH_W-1:0]        s1_tag;
    logic                      s1_hit;
    logic signed [SCORE_W-1:0] s1_prod;
    logic signed [SCORE_W-1:0] s1_bterm;
    logic signed [VAL_W-1:0]   r_bias_coef;

    // stage 2: products
    logic                      r_s2_vld;
    t_op                       r_s2_op;
    logic                      r_s2_last;
    logic [INST_W-1:0]         r_s2_inst;
    logic signed [SCORE_W-1:0] r_s2_prod;
    logic signed [SCORE_W-1:0] r_s2_bterm;

    // stage 3: accumulator and finished score
    logic signed [SCORE_W-1:0] r_acc;
    logic [SCORE_W:0]          s2_sum;
    logic signed [SCORE_W-1:0] s2_sat;
    logic                      r_s3_vld;
    logic [INST_W-1:0]         r_s3_inst;
    logic signed [SCORE_W-1:0] r_s3_score;
    logic signed [SCORE_W-1:0] r_s3_bterm;
    logic [SCORE_W:0]          s3_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= i_issue.vld;
        end
        r_s1.op       <= i_issue.op;
        r_s1.in_range <= i_issue.in_range;
        r_s1.last     <= i_issue.last;
        r_s1.inst     <= i_issue.inst;
        r_s1.value    <= i_issue.value;
        r_s1.epoch    <= i_issue.epoch;
    end

    assign s1_weight = $signed(i_rdata[VAL_W-1:0]);
    assign s1_tag    = i_rdata[MEM_W-1:VAL_W];
    assign s1_hit    = r_s1.vld && (r_s1.op == OP_FEATURE) && r_s1.in_range &&
                       (s1_tag == r_s1.epoch);
    assign s1_prod   = s1_weight * $signed(r_s1.value);
    // bias coefficient seen here already reflects every earlier item
    assign s1_bterm  = r_bias_coef * i_bias_input;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_coef <= '0;
            r_s2_vld    <= 1'b0;
        end else begin
            r_s2_vld <= r_s1.vld;
            if (r_s1.vld) begin
                case (r_s1.op)
                    OP_BEGIN: begin
                        r_bias_coef <= '0;
                    end
                    OP_BIAS: begin
                        r_bias_coef <= r_s1.value;
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_s2_op    <= r_s1.op;
        r_s2_last  <= r_s1.last;
        r_s2_inst  <= r_s1.inst;
        r_s2_prod  <= s1_hit ? s1_prod : '0;
        r_s2_bterm <= s1_bterm;
    end

    // saturating add, clamp is not sticky
    assign s2_sum = {r_acc[SCORE_W-1], r_acc} + {r_s2_prod[SCORE_W-1], r_s2_prod};

    always_comb begin
        if (s2_sum[SCORE_W] != s2_sum[SCORE_W-1]) begin
            s2_sat = s2_sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end else begin
            s2_sat = $signed(s2_sum[SCORE_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld && (r_s2_op == OP_FEATURE) && r_s2_last;
            if (r_s2_vld) begin
                case (r_s2_op)
                    OP_BEGIN: begin
                        r_acc <= '0;
                    end
                    OP_FEATURE: begin
                        r_acc <= r_s2_last ? '0 : s2_sat;
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_s3_inst  <= r_s2_inst;
        r_s3_score <= s2_sat;
        r_s3_bterm <= r_s2_bterm;
    end

    // exact sign of score plus bias term, one bit wider than either
    assign s3_total = {r_s3_score[SCORE_W-1], r_s3_score} +
                      {r_s3_bterm[SCORE_W-1], r_s3_bterm};

    assign o_res_vld        = r_s3_vld;
    assign o_res.inst       = r_s3_inst;
    assign o_res.goes_right = ~s3_total[SCORE_W];
    assign o_res.score      = r_s3_score;

endmodule

FILE: hw/rtl/slnr_outq.sv
// result queue between the mac pipeline and the output channel
// depends on slnr_pkg for the result struct and queue depth
module slnr_outq import slnr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_vld,
    output t_result o_data
);

    t_result               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [CREDIT_W-1:0]   r_count;
    logic [CREDIT_W-1:0]   n_count;

    function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
        ptr_inc = (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign n_count = r_count + CREDIT_W'(i_push) - CREDIT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_vld  = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];

endmodule

FILE: hw/rtl/slnr_checker.sv
// port-level checks of the router: output hold under stall, reset behavior
// depends on slnr_pkg; bound to sparse_linear_node_router_top below
module slnr_checker import slnr_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_stall,
    input logic                      i_out_valid,
    input logic                      i_out_stall,
    input logic [INST_W-1:0]         i_out_inst,
    input logic                      i_out_goes_right,
    input logic signed [SCORE_W-1:0] i_out_score
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            $stable(i_out_score) && $stable(i_out_inst) && $stable(i_out_goes_right))
        else $error("stalled result changed");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // the clearing pass holds the input off right after reset
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> i_in_stall)
        else $error("input open during clearing pass");

    a_clear_stall_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |=> i_in_stall)
        else $error("clearing pass ended too early");

endmodule

bind sparse_linear_node_router_top slnr_checker u_slnr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_stall       (o_stall),
    .i_out_valid      (o_valid),
    .i_out_stall      (i_stall),
    .i_out_inst       (o_routed_instance),
    .i_out_goes_right (o_goes_right),
    .i_out_score      (o_score)
);

FILE: dv/slnr_route_sb_pkg.sv
// route scoreboard of the sparse linear node router: predicts routes from the accepted
// input transfers and checks every route transfer that leaves the block
// depends on slnr_pkg for widths, kind codes, reset values and the result layout
package slnr_route_sb_pkg;
    import slnr_pkg::*;

    class route_scoreboard;
        logic signed [VAL_W-1:0]   weight_mem [int];  // present weights only
        logic signed [VAL_W-1:0]   bias_coef;
        logic signed [SCORE_W-1:0] dot_acc;
        logic [FC_W-1:0]           feat_count;
        logic signed [VAL_W-1:0]   bias_in;
        t_result                   owed_routes [$];
        int                        mismatches;

        function new();
            bias_coef  = '0;
            dot_acc    = '0;
            feat_count = FC_RESET;
            bias_in    = BIAS_RESET;
            mismatches = 0;
        endfunction

        function void set_config(logic [FC_W-1:0] fc, logic signed [VAL_W-1:0] bias);
            feat_count = fc;
            bias_in    = bias;
        endfunction

        function int pending();
            return owed_routes.size();
        endfunction

        // exact 64x64 product of two sign-extended q16.16 values
        function logic signed [SCORE_W-1:0] wide_mul(logic signed [VAL_W-1:0] a,
                                                     logic signed [VAL_W-1:0] b);
            return {{(SCORE_W-VAL_W){a[VAL_W-1]}}, a} * {{(SCORE_W-VAL_W){b[VAL_W-1]}}, b};
        endfunction

        function logic signed [SCORE_W-1:0] clamp_add(logic signed [SCORE_W-1:0] a,
                                                      logic signed [SCORE_W-1:0] b);
            logic signed [SCORE_W-1:0] sum;
            sum = a + b;
            if (a[SCORE_W-1] == b[SCORE_W-1] && sum[SCORE_W-1] != a[SCORE_W-1])
                return a[SCORE_W-1] ? SCORE_MIN : SCORE_MAX;
            return sum;
        endfunction

        function void note_transfer(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                    logic signed [VAL_W-1:0] val, logic [INST_W-1:0] inst,
                                    logic last);
            logic [SCORE_W-1:0] bterm;
            logic [SCORE_W:0]   total;
            t_result            route;
            case (kind)
                KIND_BEGIN: begin
                    weight_mem.delete();
                    bias_coef = '0;
                    dot_acc   = '0;
                end
                KIND_WEIGHT: begin
                    if (idx == feat_count)
                        bias_coef = val;
                    else if (idx < feat_count && idx < FEATURE_SLOTS)
                        weight_mem[int'(idx)] = val;
                end
                KIND_FEATURE: begin
                    if (idx < feat_count && idx < FEATURE_SLOTS && weight_mem.exists(int'(idx)))
                        dot_acc = clamp_add(dot_acc, wide_mul(weight_mem[int'(idx)], val));
                    if (last) begin
                        // decision on the unsaturated sum, one extra bit is enough
                        bterm = wide_mul(bias_coef, bias_in);
                        total = {dot_acc[SCORE_W-1], dot_acc} + {bterm[SCORE_W-1], bterm};
                        route.inst       = inst;
                        route.goes_right = ~total[SCORE_W];
                        route.score      = dot_acc;
                        owed_routes.insert(owed_routes.size(), route);
                        dot_acc = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string field, logic [SCORE_W-1:0] want, logic [SCORE_W-1:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_route(logic [INST_W-1:0] inst, logic goes_right,
                                  logic signed [SCORE_W-1:0] score);
            t_result want;
            if (owed_routes.size() == 0) begin
                report("unexpected route transfer, instance", '0, SCORE_W'(inst));
                return;
            end
            want = owed_routes.pop_front();
            if (inst !== want.inst)
                report("routed_instance", SCORE_W'(want.inst), SCORE_W'(inst));
            if (goes_right !== want.goes_right)
                report("goes_right", SCORE_W'(want.goes_right), SCORE_W'(goes_right));
            if (score !== want.score)
                report("score", want.score, score);
        endfunction
    endclass

endpackage

FILE: dv/tb_top.sv
// regression bench of sparse_linear_node_router_top: directed corner items, then random
// nodes and instances with random idling on both channels, checked by route_scoreboard
// depends on slnr_pkg, slnr_route_sb_pkg and the rtl of the block
module tb_top;
    import slnr_pkg::*;
    import slnr_route_sb_pkg::*;

    localparam int     CLK_PERIOD   = 20;
    localparam longint RUN_LIMIT    = 64'd20 * 64'd600_000;
    localparam int     RANDOM_ITEMS = 1750;
    localparam int     CALM_ITEMS   = 300;
    localparam int     DRAIN_GAP    = 8;
    localparam int     END_GAP      = 16;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam logic [IDX_W-1:0]  IDX_TOP       = 17'd65536;
    localparam logic [VAL_W-1:0]  VAL_MAX       = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  VAL_MIN       = 32'h8000_0000;
    localparam logic [VAL_W-1:0]  VAL_ONE       = 32'h0001_0000;
    localparam logic [VAL_W-1:0]  VAL_NEG_LSB   = 32'hFFFF_FFFF;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_stall;
    logic [KIND_W-1:0]         i_kind        = '0;
    logic [IDX_W-1:0]          i_index       = '0;
    logic signed [VAL_W-1:0]   i_value       = '0;
    logic [INST_W-1:0]         i_instance_id = '0;
    logic                      i_last        = 1'b0;
    logic                      o_valid;
    logic                      i_stall       = 1'b0;
    logic [INST_W-1:0]         o_routed_instance;
    logic                      o_goes_right;
    logic signed [SCORE_W-1:0] o_score;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data    = '0;

    route_scoreboard sb = new();

    logic [FC_W-1:0] cur_fc     = FC_RESET;
    int              live_idx [$];       // indices holding a present weight
    int              item_count = 0;
    int              stall_left = 0;
    bit              calm       = 1'b0;

    sparse_linear_node_router_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_index           (i_index),
        .i_value           (i_value),
        .i_instance_id     (i_instance_id),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_routed_instance (o_routed_instance),
        .o_goes_right      (o_goes_right),
        .o_score           (o_score),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return r[0] ? VAL_NEG_LSB : '0;
            3, 4, 5: return r;
            default: return {{14{r[17]}}, r[17:0]};
        endcase
    endfunction

    // the block is only written between phases, with nothing in flight
    task automatic write_config(input logic [FC_W-1:0] fc, input logic [VAL_W-1:0] bias);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FEATURE_COUNT;
        i_cfg_data <= CFG_DATA_W'(fc);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BIAS_INPUT;
        i_cfg_data <= bias;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_config(fc, bias);
        cur_fc = fc;
    endtask

    task automatic drive_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val, input logic [INST_W-1:0] inst,
                              input logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_index       <= idx;
        i_value       <= val;
        i_instance_id <= inst;
        i_last        <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_transfer(kind, idx, val, inst, last);
        if (kind == KIND_BEGIN)
            live_idx.delete();
        else if (kind == KIND_WEIGHT && idx < cur_fc)
            live_idx.insert(live_idx.size(), int'(idx));
        if (kind != KIND_RESERVED)
            item_count++;
    endtask

    task automatic drain_routes();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // items without a route may still be in the pipe
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // result side: check each route transfer, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0)
            sb.check_route(o_routed_instance, o_goes_right, o_score);
        if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0)
                i_stall <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left = $urandom_range(1, 10);
        end
    end

    initial begin
        logic [FC_W-1:0]  fc;
        logic [VAL_W-1:0] bias;
        logic [IDX_W-1:0] idx;
        int               n_feat;
        logic [INST_W-1:0] inst;
        bit               drop_last;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: feature count 8, bias input 1.0
        write_config(17'd8, VAL_ONE);
        drive_item(KIND_BEGIN, '0, '0, '0, 1'b0);
        drive_item(KIND_WEIGHT, 17'd1, 32'd3, '0, 1'b0);
        drive_item(KIND_WEIGHT, 17'd0, VAL_MAX, '0, 1'b0);
        drive_item(KIND_WEIGHT, 17'd1, VAL_MIN, '0, 1'b0);          // overwrite
        drive_item(KIND_WEIGHT, 17'd7, VAL_NEG_LSB, '0, 1'b0);
        drive_item(KIND_WEIGHT, 17'd8, VAL_MIN, '0, 1'b0);          // bias coefficient
        drive_item(KIND_WEIGHT, 17'd9, 32'd5, '0, 1'b0);            // above feature count
        drive_item(KIND_WEIGHT, IDX_TOP, VAL_MAX, 20'hFFFFF, 1'b1); // ignored, last too
        drive_item(KIND_FEATURE, 17'd0, VAL_MIN, 20'd1, 1'b0);
        repeat (2) drive_item(KIND_FEATURE, 17'd1, VAL_MIN, 20'd1, 1'b0);
        drive_item(KIND_FEATURE, 17'd1, VAL_MIN, 20'hFFFFF, 1'b1);  // clamps high
        drive_item(KIND_FEATURE, 17'd5, VAL_MAX, '0, 1'b1);         // absent weight
        drive_item(KIND_RESERVED, 17'd0, VAL_MAX, 20'd3, 1'b1);
        drive_item(KIND_WEIGHT, 17'd8, 32'd1, '0, 1'b0);
        drive_item(KIND_FEATURE, 17'd7, VAL_ONE, 20'd2, 1'b1);      // sum exactly zero
        drive_item(KIND_FEATURE, 17'd7, VAL_ONE + 32'd1, 20'd3, 1'b1);
        repeat (2) drive_item(KIND_FEATURE, 17'd0, VAL_MIN, 20'd4, 1'b0);
        drive_item(KIND_FEATURE, 17'd0, VAL_MIN, 20'd4, 1'b1);      // clamps low
        drive_item(KIND_FEATURE, IDX_TOP, VAL_MAX, 20'd5, 1'b1);    // index out of range
        drive_item(KIND_BEGIN, IDX_TOP, VAL_MIN, 20'hFFFFF, 1'b1);
        drive_item(KIND_FEATURE, 17'd0, VAL_MAX, 20'd6, 1'b1);      // marks cleared
        item_count = 0;

        for (int phase = 0; item_count < RANDOM_ITEMS; phase++) begin
            drain_routes();
            case (phase)
                0: begin
                    fc   = 17'd1;
                    bias = VAL_MIN;
                end
                1: begin
                    fc   = FC_RESET;
                    bias = VAL_MAX;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: fc = 17'd1;
                        1: fc = FC_RESET;
                        2: fc = 17'($urandom_range(2, 16));
                        3, 4: fc = 17'($urandom_range(17, 300));
                        default: fc = 17'($urandom_range(1, 65536));
                    endcase
                    bias = pick_value();
                end
            endcase
            write_config(fc, bias);

            repeat ($urandom_range(1, 3)) begin
                if (item_count >= RANDOM_ITEMS - CALM_ITEMS)
                    calm <= 1'b1;
                // a node now and then keeps the weights of the one before
                if ($urandom_range(0, 9) != 0)
                    drive_item(KIND_BEGIN, 17'($urandom_range(0, 65536)), $urandom,
                               20'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 12)) begin
                    case ($urandom_range(0, 19))
                        0: idx = cur_fc;
                        1: idx = (cur_fc == FC_RESET) ? cur_fc
                                 : 17'($urandom_range(int'(cur_fc) + 1, 65536));
                        default: idx = 17'($urandom_range(0, int'(cur_fc) - 1));
                    endcase
                    drive_item(KIND_WEIGHT, idx, pick_value(), 20'($urandom), 1'($urandom));
                end
                repeat ($urandom_range(1, 6)) begin
                    n_feat    = $urandom_range(1, 8);
                    inst      = 20'($urandom);
                    drop_last = ($urandom_range(0, 14) == 0);
                    for (int j = 0; j < n_feat; j++) begin
                        if ($urandom_range(0, 11) == 0)
                            drive_item(2'($urandom), 17'($urandom_range(0, 65536)), $urandom,
                                       20'($urandom), 1'($urandom));
                        if (live_idx.size() != 0 && $urandom_range(0, 3) != 0)
                            idx = 17'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
                        else
                            idx = 17'($urandom_range(0, 65536));
                        drive_item(KIND_FEATURE, idx, pick_value(), inst,
                                   j == n_feat - 1 && !drop_last);
                    end
                end
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (END_GAP) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("sparse_linear_node_router_top regression: pass");
        else
            $display("sparse_linear_node_router_top regression: fail");
        $finish;
    end

    // covers the clearing pass after reset and the slowest legal handshaking
    initial begin
        #(RUN_LIMIT);
        $display("sparse_linear_node_router_top regression: fail");
        $finish;
    end

endmodule
